>>> src/array_deque_linear_defines.svh
// assertion macros for the linear array deque
`ifndef ARRAY_DEQUE_LINEAR_DEFINES_SVH
`define ARRAY_DEQUE_LINEAR_DEFINES_SVH

// condition in this cycle implies consequence in the next cycle
`define ADL_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("deque assertion failed");

// condition implies consequence in the same cycle
`define ADL_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("deque assertion failed");

`endif

>>> src/adl_pkg.sv
// shared types and constants of the linear array deque
package adl_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 8;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_REAR  = 2'd0,
		REQ_DEL_FRONT = 2'd1,
		REQ_INS_FRONT = 2'd2,
		REQ_DEL_REAR  = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL_REAR = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NO_FRONT  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_READ = 1'b1
	} state_t;

	// decision for one request, from the pointer unit to the top level
	typedef struct packed {
		status_t status;
		logic    wr_en;
		logic    rd_en;
	} dec_t;

endpackage

>>> src/adl_mem.sv
// slot storage: single port synchronous memory with a registered read port
module adl_mem import adl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic signed [DATA_W-1:0] wr_data,
	output logic signed [DATA_W-1:0] rd_data
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/adl_ctrl.sv
// head and tail pointers with the per-request decision logic
module adl_ctrl import adl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  req_t                     req,
	input  logic [CAP_W-1:0]         cap,
	output dec_t                     dec,
	output logic [$clog2(DEPTH)-1:0] addr
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

	logic [IDX_W-1:0] head_q, tail_q, head_nxt, tail_nxt;
	logic             empty_q, empty_nxt;
	logic [CMP_W-1:0] cap_ext, depth_c, cap_eff, tail_inc;

	always_comb begin
		cap_ext  = CMP_W'(cap);
		depth_c  = CMP_W'(DEPTH);
		cap_eff  = (cap_ext > depth_c) ? depth_c : cap_ext;
		tail_inc = CMP_W'(tail_q) + CMP_W'(1);
	end

	always_comb begin
		dec.status = ST_DONE;
		dec.wr_en  = 1'b0;
		dec.rd_en  = 1'b0;
		addr       = '0;
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		empty_nxt  = empty_q;
		case (req)
			REQ_INS_REAR: begin
				if (empty_q) begin
					if (cap_eff == '0) begin
						dec.status = ST_FULL_REAR;
					end else begin
						dec.wr_en = 1'b1;
						head_nxt  = '0;
						tail_nxt  = '0;
						empty_nxt = 1'b0;
					end
				end else if (tail_inc >= cap_eff) begin
					dec.status = ST_FULL_REAR;
				end else begin
					dec.wr_en = 1'b1;
					addr      = tail_q + IDX_W'(1);
					tail_nxt  = tail_q + IDX_W'(1);
				end
			end
			REQ_DEL_FRONT: begin
				if (empty_q) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.rd_en = 1'b1;
					addr      = head_q;
					if (head_q >= tail_q) begin
						head_nxt  = '0;
						tail_nxt  = '0;
						empty_nxt = 1'b1;
					end else begin
						head_nxt = head_q + IDX_W'(1);
					end
				end
			end
			REQ_INS_FRONT: begin
				if (empty_q) begin
					dec.wr_en = 1'b1;
					head_nxt  = '0;
					tail_nxt  = '0;
					empty_nxt = 1'b0;
				end else if (head_q == '0) begin
					dec.status = ST_NO_FRONT;
				end else begin
					dec.wr_en = 1'b1;
					addr      = head_q - IDX_W'(1);
					head_nxt  = head_q - IDX_W'(1);
				end
			end
			REQ_DEL_REAR: begin
				if (empty_q) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.rd_en = 1'b1;
					addr      = tail_q;
					if (tail_q <= head_q) begin
						head_nxt  = '0;
						tail_nxt  = '0;
						empty_nxt = 1'b1;
					end else begin
						tail_nxt = tail_q - IDX_W'(1);
					end
				end
			end
			default: begin
				dec.status = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			empty_q <= empty_nxt;
		end
	end

endmodule

>>> src/array_deque_linear.sv
// top level of the linear array deque
`include "array_deque_linear_defines.svh"

// Double-ended queue held in a linear (non-circular) array of DEPTH 32-bit
// slots. Every request transaction on the s_ side answers exactly one result
// transaction on the m_ side, in order. Live entries sit in the contiguous
// slots head..tail; rear inserts grow upward and stop at the capacity
// register (clipped to DEPTH), front inserts grow toward slot zero and fail
// once the head is at slot zero. An insert into an empty queue lands in slot
// zero unless it is a rear insert under a capacity of zero, and a delete that
// empties the queue sends both pointers back to slot zero. Inserts and failed
// requests stream at one per cycle while m_tready is high. A successful
// delete goes through the read state: the slot is read through the
// synchronous memory port, whose data comes back in the next cycle, and no
// new request is taken in the read state. A new request is taken in the same
// cycle that the previous result leaves; while a result waits on m_tready,
// s_tready stays low. The capacity register may be written while the block is
// idle; cfg_ready is always high. Slot contents need no clearing after reset.
module array_deque_linear import adl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] data_in
	input  logic [REQ_W-1:0]         s_tuser,   // [1:0] req_type
	// result channel
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic signed [DATA_W-1:0] m_tdata,   // [31:0] data_out
	output logic [STAT_W-1:0]        m_tuser,   // [1:0] status
	// capacity register write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);

	state_t                   state_q, state_nxt;
	logic                     accept;
	logic                     rd_done;
	dec_t                     dec;
	logic [IDX_W-1:0]         mem_addr;
	logic signed [DATA_W-1:0] mem_rd_data;
	logic [CAP_W-1:0]         cap_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_data_q;

	// capacity register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	assign accept = s_tvalid && s_tready;

	adl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req_t'(s_tuser)),
		.cap    (cap_q),
		.dec    (dec),
		.addr   (mem_addr)
	);

	adl_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (accept && dec.wr_en),
		.rd_en   (accept && dec.rd_en),
		.addr    (mem_addr),
		.wr_data (s_tdata),
		.rd_data (mem_rd_data)
	);

	// sequencer: a successful delete waits in the read state for the memory read
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept && dec.rd_en) begin
					state_nxt = FSM_READ;
				end
			end
			FSM_READ: begin
				state_nxt = FSM_IDLE;
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_done  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				// take a request when the result slot is free or draining
				s_tready = !out_valid_q || m_tready;
			end
			FSM_READ: begin
				rd_done = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_done || (accept && !dec.rd_en)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_done) begin
			out_status_q <= ST_DONE;
			out_data_q   <= mem_rd_data;
		end else if (accept && !dec.rd_en) begin
			// inserts and failed requests carry zero data
			out_status_q <= dec.status;
			out_data_q   <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// a read cycle always ends with a result ready
	`ADL_ASSERT_NEXT(a_read_gives_result, state_q == FSM_READ, m_tvalid)
	// no request is taken while a read is in flight
	`ADL_ASSERT_NOW(a_no_accept_in_read, state_q == FSM_READ, !s_tready)
	// a delete that reads memory moves into the read cycle
	`ADL_ASSERT_NEXT(a_delete_reads, accept && dec.rd_en, state_q == FSM_READ)

endmodule

>>> tb/deque_checker.sv
// checker that predicts every deque reply and compares it with the result channel
module deque_checker import adl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic [REQ_W-1:0]  s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic [STAT_W-1:0] m_tuser,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	output int                fail_count,
	output int                replies_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = $clog2(DEPTH);

	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] value;
	} reply_t;

	reply_t            replies_due[$];
	reply_t            oldest;
	logic [DATA_W-1:0] slots [DEPTH];
	logic [IDX_W-1:0]  head;
	logic [IDX_W-1:0]  tail;
	logic              empty;
	logic [CAP_W-1:0]  capacity;
	int                errors;

	function automatic void go_empty();
		head  = '0;
		tail  = '0;
		empty = 1'b1;
	endfunction

	// apply one request to the shadow deque and return the reply it earns
	function automatic reply_t serve_request(req_t kind, logic [DATA_W-1:0] din);
		reply_t r;
		int     usable;
		r.status = ST_DONE;
		r.value  = '0;
		usable   = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
		case (kind)
			REQ_INS_REAR: begin
				if (empty) begin
					if (usable == 0) begin
						r.status = ST_FULL_REAR;
					end else begin
						slots[0] = din;
						head     = '0;
						tail     = '0;
						empty    = 1'b0;
					end
				end else if (int'(tail) + 1 >= usable) begin
					r.status = ST_FULL_REAR;
				end else begin
					tail        = tail + IDX_W'(1);
					slots[tail] = din;
				end
			end
			REQ_DEL_FRONT: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = slots[head];
					if (head >= tail) go_empty();
					else head = head + IDX_W'(1);
				end
			end
			REQ_INS_FRONT: begin
				if (empty) begin
					slots[0] = din;
					head     = '0;
					tail     = '0;
					empty    = 1'b0;
				end else if (head == '0) begin
					r.status = ST_NO_FRONT;
				end else begin
					head        = head - IDX_W'(1);
					slots[head] = din;
				end
			end
			default: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = slots[tail];
					if (tail <= head) go_empty();
					else tail = tail - IDX_W'(1);
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replies_due.delete();
			go_empty();
			capacity        = CAP_RESET;
			errors          = 0;
			fail_count      <= 0;
			replies_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) capacity = cfg_data;
			// results come out only after their request has been taken
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, status %0d data %h",
						$time, m_tuser, m_tdata);
				end else begin
					oldest = replies_due.pop_front();
					if (m_tuser !== oldest.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, oldest.status, m_tuser);
					end
					if (m_tdata !== oldest.value) begin
						errors++;
						$display("%0t: data mismatch, expected %h actual %h",
							$time, oldest.value, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				replies_due.push_back(serve_request(req_t'(s_tuser), s_tdata));
			end
			fail_count      <= errors;
			replies_waiting <= replies_due.size();
		end
	end

endmodule

>>> tb/testbench.sv
// top of the deque testbench: clock, reset, request and capacity stimulus, verdict
module testbench;
	import adl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

	// capacity and length of each random phase; the last capacity is drawn at random
	localparam int PHASES = 9;
	localparam int PHASE_CAP [PHASES] = '{128, 2, 0, 255, 1, 64, 129, 7, 0};
	localparam int PHASE_LEN [PHASES] = '{220, 80, 40, 220, 60, 150, 150, 80, 100};

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic signed [DATA_W-1:0] s_tdata;   // [31:0] data_in
	logic [REQ_W-1:0]         s_tuser;   // [1:0] req_type
	logic                     m_tvalid;
	logic                     m_tready;
	logic signed [DATA_W-1:0] m_tdata;   // [31:0] data_out
	logic [STAT_W-1:0]        m_tuser;   // [1:0] status
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data;
	int                       fail_count;
	int                       replies_waiting;
	logic                     calm;      // no idling on either side while set

	array_deque_linear #(
		.DEPTH(DEPTH_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	deque_checker #(
		.DEPTH(DEPTH_DEF)
	) replies (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.replies_waiting(replies_waiting)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// result side backpressure, about 18 stall cycles in a hundred
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 18);
	end

	// one request transaction, with random idle cycles ahead of it
	task automatic send_request(req_t kind, logic [DATA_W-1:0] value);
		while (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold off requests until every reply is in, plus a little slack for the pipeline
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (replies_waiting != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// capacity writes only go in with the deque idle
	task automatic set_capacity(logic [CAP_W-1:0] value);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly random words, now and then one of the extremes
	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: return '0;
				1: return MOST_NEG;
				2: return MOST_POS;
				default: return ALL_ONES;
			endcase
		end
		return $urandom();
	endfunction

	// filling mix drives the deque toward full, draining mix toward empty
	function automatic req_t pick_request(bit filling);
		int roll;
		roll = $urandom_range(99);
		if (filling) begin
			if (roll < 70) return REQ_INS_REAR;
			if (roll < 80) return REQ_INS_FRONT;
			if (roll < 95) return REQ_DEL_FRONT;
			return REQ_DEL_REAR;
		end
		if (roll < 10) return REQ_INS_REAR;
		if (roll < 25) return REQ_INS_FRONT;
		if (roll < 65) return REQ_DEL_FRONT;
		return REQ_DEL_REAR;
	endfunction

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_INS_REAR;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// deletes on an empty deque
		send_request(REQ_DEL_FRONT, ALL_ONES);
		send_request(REQ_DEL_REAR, MOST_POS);
		// front insert into empty lands in slot zero, a second one has no room
		send_request(REQ_INS_FRONT, MOST_NEG);
		send_request(REQ_INS_FRONT, ALL_ONES);
		send_request(REQ_INS_REAR, MOST_POS);
		send_request(REQ_INS_REAR, '0);
		// free slot zero, then refill it from the front
		send_request(REQ_DEL_FRONT, '0);
		send_request(REQ_INS_FRONT, 32'h5555_5555);
		send_request(REQ_DEL_REAR, '0);
		send_request(REQ_DEL_REAR, '0);
		send_request(REQ_DEL_FRONT, '0);
		send_request(REQ_DEL_REAR, '0);

		// zero capacity: rear inserts always full, front insert into empty still works
		set_capacity(8'd0);
		send_request(REQ_INS_REAR, 32'h1234_5678);
		send_request(REQ_INS_FRONT, ALL_ONES);
		send_request(REQ_INS_REAR, 32'h0f0f_0f0f);
		send_request(REQ_DEL_REAR, '0);

		// fill a small deque up to full at the rear
		set_capacity(8'd3);
		send_request(REQ_INS_REAR, 32'haaaa_aaaa);
		send_request(REQ_INS_REAR, 32'h5555_5555);
		send_request(REQ_INS_REAR, MOST_NEG);
		send_request(REQ_INS_REAR, MOST_POS);

		// capacity lowered below the tail
		set_capacity(8'd1);
		send_request(REQ_INS_REAR, 32'hdead_beef);
		send_request(REQ_DEL_FRONT, '0);
		send_request(REQ_DEL_REAR, '0);
		send_request(REQ_DEL_REAR, '0);
		send_request(REQ_INS_REAR, 32'hc001_d00d);
		send_request(REQ_INS_REAR, 32'h0000_0001);
		send_request(REQ_DEL_FRONT, '0);

		// random phases, each filling first and draining after
		for (int p = 0; p < PHASES; p++) begin
			set_capacity((p == PHASES - 1) ? CAP_W'($urandom_range(255)) : CAP_W'(PHASE_CAP[p]));
			calm <= (p == 3);
			for (int i = 0; i < PHASE_LEN[p]; i++) begin
				// one pause mid-phase until every reply has come back
				if (p == 5 && i == PHASE_LEN[p] / 2) wait_quiet();
				send_request(pick_request(i < PHASE_LEN[p] * 3 / 5), pick_value());
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && replies_waiting == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
